FILE: src/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, constants and character helpers shared by the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Line feed ends header and size lines
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // Length of the lowercase "transfer-encoding: chunked" pattern
    localparam logic [4:0] PATTERN_LEN = 5'd26;

    // Response phase, one-hot
    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_SIZE   = 6'b000010,
        PH_DATA   = 6'b000100,
        PH_SKIP   = 6'b001000,
        PH_IDLE   = 6'b010000,
        PH_FIN    = 6'b100000
    } phase_t;

    // Size line parse step, one-hot
    typedef enum logic [4:0] {
        SP_LEAD   = 5'b00001,
        SP_SIGNED = 5'b00010,
        SP_ZERO   = 5'b00100,
        SP_DIGITS = 5'b01000,
        SP_STOP   = 5'b10000
    } size_step_t;

    // Status from the header line matcher
    typedef struct packed {
        logic blank_end;   // LF closing a blank line (end of header)
        logic chunked;     // chunked encoding line seen so far
    } hdr_status_t;

    // Pattern byte at a match position
    function automatic logic [7:0] pattern_char(input logic [4:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                5'd0:    ch = "t";
                5'd1:    ch = "r";
                5'd2:    ch = "a";
                5'd3:    ch = "n";
                5'd4:    ch = "s";
                5'd5:    ch = "f";
                5'd6:    ch = "e";
                5'd7:    ch = "r";
                5'd8:    ch = "-";
                5'd9:    ch = "e";
                5'd10:   ch = "n";
                5'd11:   ch = "c";
                5'd12:   ch = "o";
                5'd13:   ch = "d";
                5'd14:   ch = "i";
                5'd15:   ch = "n";
                5'd16:   ch = "g";
                5'd17:   ch = ":";
                5'd18:   ch = " ";
                5'd19:   ch = "c";
                5'd20:   ch = "h";
                5'd21:   ch = "u";
                5'd22:   ch = "n";
                5'd23:   ch = "k";
                5'd24:   ch = "e";
                5'd25:   ch = "d";
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    // Tab, LF, VT, FF, CR and space
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? (c + 8'h20) : c;
    endfunction

    // Hex digit value; bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        begin
            if (c inside {[8'h30:8'h39]}) begin
                v = {1'b0, c[3:0]};
            end else if ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]})) begin
                v = {1'b0, c[3:0] + 4'd9};
            end else begin
                v = 5'h10;
            end
            return v;
        end
    endfunction

endpackage

FILE: src/hcbd_hdr_match.sv
// ----------------------------------------------------------------------------
// hcbd_hdr_match
// Header line matcher: trims each line and compares it, ignoring case,
// against the chunked transfer-encoding line; flags the blank line.
// ----------------------------------------------------------------------------
module hcbd_hdr_match (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,       // header byte to consume
    input  logic                clear,    // response ends: back to reset state
    input  logic [7:0]          ch,
    output hcbd_pkg::hdr_status_t status
);

    logic [4:0] pos_reg,      pos_next;
    logic       failed_reg,   failed_next;
    logic       nonblank_reg, nonblank_next;
    logic       chunked_reg,  chunked_next;

    // Advance the line match on one header byte
    always_comb
    begin
        pos_next      = pos_reg;
        failed_next   = failed_reg;
        nonblank_next = nonblank_reg;
        chunked_next  = chunked_reg;
        if (en) begin
            if (ch == hcbd_pkg::CH_LF) begin
                if (nonblank_reg && !failed_reg && (pos_reg == hcbd_pkg::PATTERN_LEN)) begin
                    chunked_next = 1'b1;
                end
                pos_next      = '0;
                failed_next   = 1'b0;
                nonblank_next = 1'b0;
            end else if (!(!nonblank_reg && hcbd_pkg::is_ws(ch))) begin
                nonblank_next = 1'b1;
                if (!failed_reg) begin
                    if ((pos_reg < hcbd_pkg::PATTERN_LEN) &&
                        (hcbd_pkg::to_lower(ch) == hcbd_pkg::pattern_char(pos_reg))) begin
                        pos_next = pos_reg + 5'd1;
                    end else if (!((pos_reg == hcbd_pkg::PATTERN_LEN) && hcbd_pkg::is_ws(ch))) begin
                        failed_next = 1'b1;
                    end
                end
            end
        end
        if (clear) begin
            pos_next      = '0;
            failed_next   = 1'b0;
            nonblank_next = 1'b0;
            chunked_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg      <= '0;
            failed_reg   <= 1'b0;
            nonblank_reg <= 1'b0;
            chunked_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            failed_reg   <= failed_next;
            nonblank_reg <= nonblank_next;
            chunked_reg  <= chunked_next;
        end
    end

    assign status.blank_end = en && (ch == hcbd_pkg::CH_LF) && !nonblank_reg;
    assign status.chunked   = chunked_reg;

endmodule

FILE: src/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Registers: input register, then result register. Throughput: one byte per
// cycle while the output is not stalled, set by the single-pass state update
// between the two registers; a one-deep input register absorbs stalls.
// Reset: asynchronous, active low; clears all parse state and the valid flags of both registers.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    // Response byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] resp_byte
    input  logic       s_tlast,   // resp_last
    // Decoded body stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] body_byte
    output logic       m_tuser,   // [0] body_valid
    output logic       m_tlast    // body_done
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Result register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bvalid_reg;
    logic       out_done_reg;

    // Parse state
    hcbd_pkg::phase_t     phase_reg, phase_next;
    hcbd_pkg::size_step_t step_reg,  step_next;
    logic [SIZE_BITS-1:0] size_reg,  size_next;
    logic [SIZE_BITS-1:0] left_reg,  left_next;

    logic                  adv;
    logic                  proc;
    logic                  res_valid;
    logic                  res_done;
    logic                  hdr_en;
    logic                  clear;
    hcbd_pkg::hdr_status_t hdr_status;
    logic [4:0]            digit;
    logic                  is_hex;
    logic [SIZE_BITS+3:0]  size_wide;
    logic [SIZE_BITS-1:0]  size_add;

    // Advance when the result register is free or being drained
    assign adv      = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;
    assign hdr_en   = proc && (phase_reg == hcbd_pkg::PH_HEADER);
    assign clear    = proc && in_last_reg;

    hcbd_hdr_match u_hdr_match (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (hdr_en),
        .clear  (clear),
        .ch     (in_byte_reg),
        .status (hdr_status)
    );

    // Hex digit append with saturation
    assign digit     = hcbd_pkg::hex_val(in_byte_reg);
    assign is_hex    = !digit[4];
    assign size_wide = {size_reg, digit[3:0]};
    assign size_add  = (|size_wide[SIZE_BITS+3:SIZE_BITS]) ? {SIZE_BITS{1'b1}}
                                                           : size_wide[SIZE_BITS-1:0];

    // Per-byte state update
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        res_valid  = 1'b0;
        res_done   = 1'b0;
        if (proc) begin
            case (phase_reg)
                hcbd_pkg::PH_HEADER:
                begin
                    if (hdr_status.blank_end) begin
                        phase_next = hdr_status.chunked ? hcbd_pkg::PH_SIZE
                                                        : hcbd_pkg::PH_IDLE;
                    end
                end
                hcbd_pkg::PH_SIZE:
                begin
                    if (in_byte_reg == hcbd_pkg::CH_LF) begin
                        if (size_reg == '0) begin
                            phase_next = hcbd_pkg::PH_FIN;
                            res_done   = 1'b1;
                        end else begin
                            left_next  = size_reg;
                            phase_next = hcbd_pkg::PH_DATA;
                        end
                        step_next = hcbd_pkg::SP_LEAD;
                        size_next = '0;
                    end else begin
                        case (step_reg)
                            hcbd_pkg::SP_LEAD,
                            hcbd_pkg::SP_SIGNED:
                            begin
                                if ((step_reg == hcbd_pkg::SP_LEAD) &&
                                    hcbd_pkg::is_ws(in_byte_reg)) begin
                                    step_next = step_reg;
                                end else if ((step_reg == hcbd_pkg::SP_LEAD) &&
                                             (in_byte_reg == hcbd_pkg::CH_PLUS)) begin
                                    step_next = hcbd_pkg::SP_SIGNED;
                                end else if ((step_reg == hcbd_pkg::SP_LEAD) &&
                                             (in_byte_reg == hcbd_pkg::CH_MINUS)) begin
                                    size_next = '0;
                                    step_next = hcbd_pkg::SP_STOP;
                                end else if (in_byte_reg == hcbd_pkg::CH_ZERO) begin
                                    step_next = hcbd_pkg::SP_ZERO;
                                end else if (is_hex) begin
                                    size_next = size_add;
                                    step_next = hcbd_pkg::SP_DIGITS;
                                end else begin
                                    step_next = hcbd_pkg::SP_STOP;
                                end
                            end
                            hcbd_pkg::SP_ZERO:
                            begin
                                if ((in_byte_reg == hcbd_pkg::CH_LOW_X) ||
                                    (in_byte_reg == hcbd_pkg::CH_UP_X)) begin
                                    step_next = hcbd_pkg::SP_DIGITS;
                                end else if (is_hex) begin
                                    size_next = size_add;
                                    step_next = hcbd_pkg::SP_DIGITS;
                                end else begin
                                    step_next = hcbd_pkg::SP_STOP;
                                end
                            end
                            hcbd_pkg::SP_DIGITS:
                            begin
                                if (is_hex) begin
                                    size_next = size_add;
                                end else begin
                                    step_next = hcbd_pkg::SP_STOP;
                                end
                            end
                            default:
                            begin
                                step_next = step_reg;
                            end
                        endcase
                    end
                end
                hcbd_pkg::PH_DATA:
                begin
                    res_valid = 1'b1;
                    left_next = left_reg - {{(SIZE_BITS-1){1'b0}}, 1'b1};
                    if (left_next == '0) begin
                        phase_next = hcbd_pkg::PH_SKIP;
                    end
                end
                hcbd_pkg::PH_SKIP:
                begin
                    if (in_byte_reg == hcbd_pkg::CH_LF) begin
                        phase_next = hcbd_pkg::PH_SIZE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            // Final byte: report done unless the body already ended, then reset
            if (in_last_reg) begin
                if (phase_reg != hcbd_pkg::PH_FIN) begin
                    res_done = 1'b1;
                end
                phase_next = hcbd_pkg::PH_HEADER;
                step_next  = hcbd_pkg::SP_LEAD;
                size_next  = '0;
                left_next  = '0;
            end
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= hcbd_pkg::PH_HEADER;
            step_reg  <= hcbd_pkg::SP_LEAD;
            size_reg  <= '0;
            left_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
        end
    end

    // Input register: take a request when empty or when the held byte moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register: load on a produced result, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= proc && (res_valid || res_done);
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc) begin
            out_byte_reg   <= res_valid ? in_byte_reg : 8'h00;
            out_bvalid_reg <= res_valid;
            out_done_reg   <= res_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_bvalid_reg;
    assign m_tlast  = out_done_reg;

`ifndef SYNTHESIS
    // Data phase always has bytes still owed
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hcbd_pkg::PH_DATA) |-> (left_reg != '0))
        else $error("data phase with zero bytes left");

    // Size accumulator is only nonzero while parsing a size line
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != hcbd_pkg::PH_SIZE) |-> (size_reg == '0))
        else $error("size value left over outside size phase");

    // A result without a data byte carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'h00))
        else $error("nonzero body byte on a done-only result");

    // After the body ends only the final byte may act, and it gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && (phase_reg == hcbd_pkg::PH_FIN)) |-> (!res_valid && !res_done))
        else $error("result produced after body end");
`endif

endmodule
